@@ src/gae_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gae_pkg: shared types, constants and helpers of the return engine
// Payload structs, register map, storage entry and saturation helpers.
// ----------------------------------------------------------------------------
package gae_pkg;

   // Sizing
   localparam int MAX_STEPS_DEF = 64;
   localparam int STEP_W        = 6;
   localparam int CSR_ADDR_W    = 4;
   localparam int CSR_DATA_W    = 32;
   localparam int RATE_W        = 17;

   // Register indexes (byte address = 4 * index)
   localparam logic [1:0] CSR_USE_GAE    = 2'd0;
   localparam logic [1:0] CSR_DISCOUNT   = 2'd1;
   localparam logic [1:0] CSR_GAE_LAMBDA = 2'd2;

   // Register reset values
   localparam logic              USE_GAE_RST    = 1'b1;
   localparam logic [RATE_W-1:0] DISCOUNT_RST   = 17'd65208;
   localparam logic [RATE_W-1:0] GAE_LAMBDA_RST = 17'd62259;
   localparam logic [RATE_W-1:0] RATE_ONE       = 17'd65536;

   typedef struct packed {
      logic signed [31:0] reward;
      logic signed [31:0] value_estimate;
      logic               continue_mask;
      logic signed [31:0] bootstrap_value;
      logic               last_step;
   } req_type;

   typedef struct packed {
      logic signed [31:0] return_value;
      logic [STEP_W-1:0]  step_index;
      logic               saturated;
      logic               last_result;
   } rsp_type;

   // One stored rollout step
   typedef struct packed {
      logic               mask;
      logic signed [31:0] value;
      logic signed [31:0] reward;
   } step_entry_type;

   typedef struct packed {
      logic              use_gae;
      logic [RATE_W-1:0] discount;
      logic [RATE_W-1:0] gae_lambda;
   } csr_type;

   // Controller -> datapath
   typedef struct packed {
      logic accept;    // input beat taken
      logic start;     // last step: set up the sweep
      logic mul_en;    // register products
      logic acc_en;    // update running accumulator
      logic out_load;  // load result register, step down
   } cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic t_zero;
      logic out_full;
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_ACC,
      ST_OUT
   } state_type;

   // Rates above 1.0 count as 1.0
   function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] r);
      return (r > RATE_ONE) ? RATE_ONE : r;
   endfunction

   // Saturate a 37-bit sum to 32 bits; MSB of the result is the clip flag
   function automatic logic [32:0] sat32(input logic signed [36:0] x);
      logic clip;
      logic [31:0] val;
      clip = !((&x[36:31]) || !(|x[36:31]));
      if (!clip) begin
         val = x[31:0];
      end else if (x[36]) begin
         val = 32'h8000_0000;
      end else begin
         val = 32'h7FFF_FFFF;
      end
      return {clip, val};
   endfunction

endpackage

@@ src/gae_return_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gae_return_engine: rollout return / advantage engine
// Stores rollout steps, then on the last step sweeps backward and emits one
// saturated return (GAE or plain discounted) per step, newest first.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_type: one rollout step
//   rsp     | out       | rsp_valid/rsp_stall | rsp_type: one return
//   csr     | in        | APB psel/penable    | use_gae, discount, gae_lambda
//
// Loading takes one cycle per step beat; the store takes one write a cycle.
// The sweep handles each stored step in three states (store read and multiply,
// accumulate, result load). No beats are taken during a sweep.
// Reset is synchronous; the step store needs no clearing pass.
// rsp_stall holds the sweep at the result load step until the register drains.
// ----------------------------------------------------------------------------
module gae_return_engine
   import gae_pkg::*;
#(
   parameter int MAX_STEPS = MAX_STEPS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   csr_type    csr_ff;
   logic       csr_wr;
   cmd_type    cmd;
   status_type status;

   // Configuration registers
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.use_gae    <= USE_GAE_RST;
         csr_ff.discount   <= DISCOUNT_RST;
         csr_ff.gae_lambda <= GAE_LAMBDA_RST;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            CSR_USE_GAE:    csr_ff.use_gae    <= csr_pwdata[0];
            CSR_DISCOUNT:   csr_ff.discount   <= csr_pwdata[RATE_W-1:0];
            CSR_GAE_LAMBDA: csr_ff.gae_lambda <= csr_pwdata[RATE_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      case (csr_paddr[3:2])
         CSR_USE_GAE:    csr_prdata = CSR_DATA_W'(csr_ff.use_gae);
         CSR_DISCOUNT:   csr_prdata = CSR_DATA_W'(csr_ff.discount);
         CSR_GAE_LAMBDA: csr_prdata = CSR_DATA_W'(csr_ff.gae_lambda);
         default:        csr_prdata = '0;
      endcase
   end

   gae_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_step),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   gae_dp #(
      .MAX_STEPS (MAX_STEPS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .csr       (csr_ff),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

@@ src/gae_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gae_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gae_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/gae_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gae_ctrl: sequencer of the return engine
// Takes input beats while idle, then walks the backward sweep one step at a
// time: read/multiply, accumulate, hand out the result.
// ----------------------------------------------------------------------------
module gae_ctrl
   import gae_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last,
   output logic       req_stall,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_last) begin
                  cmd.start = 1'b1;
                  state_in  = ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_en = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            // wait for room in the result register
            if (!status.out_full || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = status.t_zero ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ src/gae_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gae_dp: datapath of the return engine
// Step store, fill count, sweep index, multipliers, running accumulator with
// saturation and the result register.
// ----------------------------------------------------------------------------
module gae_dp
   import gae_pkg::*;
#(
   parameter int MAX_STEPS = MAX_STEPS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  csr_type    csr,
   input  req_type    req_data,
   input  logic       rsp_stall,
   output status_type status,
   output logic       rsp_valid,
   output rsp_type    rsp_data
);

   localparam int IW = $clog2(MAX_STEPS);
   localparam int FW = $clog2(MAX_STEPS + 1);

   logic [FW-1:0]       fill_ff;
   logic [IW-1:0]       t_ff;
   logic                has_room;
   step_entry_type      wr_entry;
   step_entry_type      rd_entry;

   logic [RATE_W-1:0]   gamma;
   logic [RATE_W-1:0]   tau;
   logic [33:0]         gl_prod;
   logic [RATE_W-1:0]   gl_ff;
   logic [RATE_W-1:0]   rate_sel;

   logic signed [31:0]  nv_ff;
   logic signed [31:0]  acc_ff;
   logic                clip_ff;
   logic signed [49:0]  p1_ff;
   logic signed [49:0]  p2_ff;
   logic signed [49:0]  p1_rnd;
   logic signed [49:0]  p2_rnd;
   logic signed [33:0]  q1;
   logic signed [33:0]  q2;
   logic signed [36:0]  acc_sum;
   logic [32:0]         acc_sat;
   logic signed [36:0]  out_sum;
   logic [32:0]         out_sat;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   rsp_type             rsp_data_ff;

   assign has_room = (fill_ff < FW'(MAX_STEPS));

   // Step store
   assign wr_entry.mask   = req_data.continue_mask;
   assign wr_entry.value  = req_data.value_estimate;
   assign wr_entry.reward = req_data.reward;

   gae_ram #(
      .WIDTH ($bits(step_entry_type)),
      .DEPTH (MAX_STEPS)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.accept && has_room),
      .wr_addr (fill_ff[IW-1:0]),
      .wr_data (wr_entry),
      .rd_addr (t_ff),
      .rd_data (rd_entry)
   );

   // Fill count and sweep index
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         t_ff    <= '0;
      end else begin
         if (cmd.start) begin
            fill_ff <= '0;
            t_ff    <= has_room ? fill_ff[IW-1:0] : IW'(MAX_STEPS - 1);
         end else if (cmd.accept && has_room) begin
            fill_ff <= fill_ff + FW'(1);
         end
         if (cmd.out_load && (t_ff != '0)) begin
            t_ff <= t_ff - IW'(1);
         end
      end
   end

   // Rates; gamma*tau kept registered
   assign gamma   = clamp_rate(csr.discount);
   assign tau     = clamp_rate(csr.gae_lambda);
   assign gl_prod = 34'(gamma) * 34'(tau) + 34'd32768;

   always_ff @(posedge clock) begin
      gl_ff <= gl_prod[32:16];
   end

   assign rate_sel = csr.use_gae ? gl_ff : gamma;

   // Products for this step
   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         p1_ff <= nv_ff * $signed({1'b0, gamma});
         p2_ff <= acc_ff * $signed({1'b0, rate_sel});
      end
   end

   // Round to nearest, ties up
   assign p1_rnd = p1_ff + 50'sd32768;
   assign p2_rnd = p2_ff + 50'sd32768;
   assign q1     = p1_rnd[49:16];
   assign q2     = p2_rnd[49:16];

   always_comb begin
      if (csr.use_gae) begin
         acc_sum = 37'(rd_entry.reward) - 37'(rd_entry.value)
                 + (rd_entry.mask ? 37'(q1) : 37'sd0)
                 + (rd_entry.mask ? 37'(q2) : 37'sd0);
      end else begin
         acc_sum = 37'(rd_entry.reward) + (rd_entry.mask ? 37'(q2) : 37'sd0);
      end
   end

   assign acc_sat = sat32(acc_sum);

   // Accumulator; nv_ff then holds this step's value for the next step down
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         nv_ff  <= req_data.bootstrap_value;
         acc_ff <= csr.use_gae ? 32'sd0 : req_data.bootstrap_value;
      end else if (cmd.acc_en) begin
         acc_ff  <= acc_sat[31:0];
         clip_ff <= acc_sat[32];
         nv_ff   <= rd_entry.value;
      end
   end

   // Result value
   assign out_sum = 37'(acc_ff) + 37'(nv_ff);
   assign out_sat = sat32(out_sum);

   // Result register
   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff.return_value <= csr.use_gae ? out_sat[31:0] : acc_ff;
         rsp_data_ff.step_index   <= STEP_W'(t_ff);
         rsp_data_ff.saturated    <= clip_ff || (csr.use_gae && out_sat[32]);
         rsp_data_ff.last_result  <= (t_ff == '0);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;
   assign status.t_zero   = (t_ff == '0);
   assign status.out_full = rsp_valid_ff;

endmodule

@@ tb/gae_return_engine_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gae_return_engine_tb: self-checking bench for the rollout return engine
// Streams rollouts of random and corner-case steps through the req channel.
// It drains the rsp channel under random and long back-pressure, and changes
// the rate and mode registers between rollouts. Every return beat is checked
// against an in-bench model of the backward GAE / discounted-return sweep.
// ----------------------------------------------------------------------------
module gae_return_engine_tb
   import gae_pkg::*;
();

   localparam int     DEPTH      = MAX_STEPS_DEF;
   localparam int     RAND_ITEMS = 180;
   localparam int     STALL_LIMIT = 4000;
   localparam int     HOLD_OFF   = 300;
   localparam longint INT_HI     = 2147483647;
   localparam longint INT_LO     = -INT_HI - 1;

   // Model of the step store and the backward sweep
   class gae_returns;
      rsp_type           pending_returns[$];
      logic              use_gae;
      logic [RATE_W-1:0] discount;
      logic [RATE_W-1:0] gae_lambda;
      int                reward_mem[DEPTH];
      int                value_mem[DEPTH];
      bit                mask_mem[DEPTH];
      int                fill;
      int                errors;

      function new();
         use_gae    = USE_GAE_RST;
         discount   = DISCOUNT_RST;
         gae_lambda = GAE_LAMBDA_RST;
         fill       = 0;
         errors     = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] val);
         case (idx)
            CSR_USE_GAE:    use_gae    = val[0];
            CSR_DISCOUNT:   discount   = val[RATE_W-1:0];
            CSR_GAE_LAMBDA: gae_lambda = val[RATE_W-1:0];
            default: ;
         endcase
      endfunction

      // Round to nearest, ties up: floor((a*r + 2^15) / 2^16)
      function longint qmul(longint a, longint r);
         return (a * r + 32768) >>> 16;
      endfunction

      function longint clip32(longint x, inout bit hit);
         if (x > INT_HI) begin
            hit = 1'b1;
            return INT_HI;
         end
         if (x < INT_LO) begin
            hit = 1'b1;
            return INT_LO;
         end
         return x;
      endfunction

      function int pending();
         return pending_returns.size();
      endfunction

      // Store one step beat; a last beat sweeps the store newest first
      function void load_step(req_type s);
         longint  gamma, tau, gl, acc, r, v, nv, delta, res, boot;
         bit      hit, m;
         rsp_type ret;
         if (fill < DEPTH) begin
            reward_mem[fill] = s.reward;
            value_mem[fill]  = s.value_estimate;
            mask_mem[fill]   = s.continue_mask;
            fill++;
         end
         if (!s.last_step) return;
         gamma = (discount > RATE_ONE) ? RATE_ONE : discount;
         tau   = (gae_lambda > RATE_ONE) ? RATE_ONE : gae_lambda;
         gl    = qmul(gamma, tau);
         boot  = longint'($signed(s.bootstrap_value));
         acc   = use_gae ? 0 : boot;
         for (int t = fill - 1; t >= 0; t--) begin
            hit = 1'b0;
            r   = reward_mem[t];
            v   = value_mem[t];
            m   = mask_mem[t];
            if (use_gae) begin
               nv    = (t == fill - 1) ? boot : longint'(value_mem[t+1]);
               delta = r + (m ? qmul(nv, gamma) : 0) - v;
               acc   = clip32(delta + (m ? qmul(acc, gl) : 0), hit);
               res   = clip32(acc + v, hit);
            end else begin
               acc = clip32(r + (m ? qmul(acc, gamma) : 0), hit);
               res = acc;
            end
            ret.return_value = res[31:0];
            ret.step_index   = t[STEP_W-1:0];
            ret.saturated    = hit;
            ret.last_result  = (t == 0);
            pending_returns.push_back(ret);
         end
         fill = 0;
      endfunction

      function void check_return(rsp_type got);
         rsp_type want;
         if (pending_returns.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected return beat: value %0d step %0d sat %0b last %0b",
                        got.return_value, got.step_index, got.saturated,
                        got.last_result);
            return;
         end
         want = pending_returns.pop_front();
         if (got.return_value !== want.return_value || got.step_index !== want.step_index ||
             got.saturated !== want.saturated || got.last_result !== want.last_result) begin
            errors++;
            if (errors <= 10)
               $display("return mismatch step %0d: want %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                        want.step_index, want.return_value, want.step_index,
                        want.saturated, want.last_result, got.return_value,
                        got.step_index, got.saturated, got.last_result);
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   gae_returns sb = new();
   bit         calm;
   bit         held;
   int         idle_cycles;
   int         items_sent;

   gae_return_engine #(.MAX_STEPS(DEPTH)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Beat monitor: predict on accepted steps, check accepted returns
   always @(posedge clock) begin
      bit moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.load_step(req_data);
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_return(rsp_data);
            moved = 1'b1;
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) moved = 1'b1;
         idle_cycles <= moved ? 0 : idle_cycles + 1;
      end
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("gae_return_engine test failed");
      $finish;
   end

   // Return side: random stall bursts plus one long hold-off mid sweep
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!calm && !held && sb.pending() >= 30) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_reg(idx, val);
   endtask

   // Drain all returns, let the engine settle, then reprogram it
   task automatic set_mode(input logic gae, input logic [RATE_W-1:0] disc,
                           input logic [RATE_W-1:0] lam);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
      repeat (16) @(posedge clock);
      csr_write(CSR_USE_GAE, {31'd0, gae});
      csr_write(CSR_DISCOUNT, {15'd0, disc});
      csr_write(CSR_GAE_LAMBDA, {15'd0, lam});
   endtask

   task automatic send_step(input req_type s);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_fixed(input logic [31:0] r, input logic [31:0] v, input logic m,
                             input logic [31:0] nv, input logic last);
      req_type s;
      s.reward          = r;
      s.value_estimate  = v;
      s.continue_mask   = m;
      s.bootstrap_value = nv;
      s.last_step       = last;
      send_step(s);
   endtask

   // Mix of extremes, small fixed-point values and full-range noise
   function automatic logic [31:0] pick_word();
      logic [31:0] w;
      case ($urandom_range(0, 7))
         0: w = 32'h7FFF_FFFF;
         1: w = 32'h8000_0000;
         2: w = 32'h0000_0000;
         3: w = 32'hFFFF_FFFF;
         4, 5: w = $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
         default: w = $urandom();
      endcase
      return w;
   endfunction

   function automatic logic [RATE_W-1:0] pick_rate();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return RATE_ONE;
         2: return {RATE_W{1'b1}};
         3: return DISCOUNT_RST;
         default: return RATE_W'($urandom_range(0, 131071));
      endcase
   endfunction

   task automatic send_rollout(input int len);
      for (int i = 0; i < len; i++) begin
         send_fixed(pick_word(), pick_word(), ($urandom_range(0, 3) != 0), pick_word(),
                    (i == len - 1));
         items_sent++;
      end
   endtask

   initial begin
      int n_roll;
      int len;
      calm        = 1'b0;
      items_sent  = 0;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset rates: single-step rollout that clips high
      send_fixed(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 1'b1);
      // Extremes with an episode end in the middle
      send_fixed(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h0, 1'b0);
      send_fixed(32'h8000_0000, 32'h0, 1'b0, 32'h7FFF_FFFF, 1'b0);
      send_fixed(32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 32'h1234_5678, 1'b0);
      send_fixed(32'h0, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000, 1'b1);

      // Both rates above one are taken as one
      set_mode(1'b1, {RATE_W{1'b1}}, {RATE_W{1'b1}});
      send_fixed(32'h0001_8000, 32'h0000_4000, 1'b1, 32'hFFFF_0000, 1'b0);
      send_fixed(32'hFFFE_8000, 32'h0003_0000, 1'b1, 32'h0, 1'b0);
      send_fixed(32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 32'h0002_8000, 1'b1);

      // Plain returns, zero discount
      set_mode(1'b0, '0, '0);
      send_fixed(32'h0002_0000, 32'h0, 1'b1, 32'h0, 1'b0);
      send_fixed(32'hFFFF_8000, 32'h7FFF_FFFF, 1'b1, 32'h0, 1'b0);
      send_fixed(32'h0000_7FFF, 32'h0, 1'b1, 32'h7FFF_FFFF, 1'b1);

      // Plain returns, unit discount: accumulation clips
      set_mode(1'b0, RATE_ONE, RATE_ONE);
      send_fixed(32'h7FFF_FFFF, 32'h0, 1'b1, 32'h0, 1'b0);
      send_fixed(32'h7FFF_FFFF, 32'h0, 1'b1, 32'h0, 1'b0);
      send_fixed(32'h8000_0000, 32'h0, 1'b0, 32'h0, 1'b0);
      send_fixed(32'h8000_0000, 32'h0, 1'b1, 32'h8000_0000, 1'b1);

      // GAE with zero discount and unit lambda
      set_mode(1'b1, '0, RATE_ONE);
      send_fixed(32'h0003_0000, 32'hFFFF_0000, 1'b1, 32'h0, 1'b0);
      send_fixed(32'hFFFD_0000, 32'h0001_0000, 1'b1, 32'h7FFF_FFFF, 1'b1);

      // Random rollouts; one overfills the store, and the first long sweep is held off
      n_roll = 0;
      while (items_sent < RAND_ITEMS) begin
         if (n_roll % 3 == 0)
            set_mode(1'($urandom_range(0, 1)), pick_rate(), pick_rate());
         if (n_roll == 3)
            len = DEPTH + 2;
         else if ($urandom_range(0, 15) == 0)
            len = $urandom_range(DEPTH - 4, DEPTH);
         else
            len = $urandom_range(1, 8);
         if (items_sent >= RAND_ITEMS - 30) calm = 1'b1;
         send_rollout(len);
         n_roll++;
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
      repeat (24) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("gae_return_engine test passed");
      end else begin
         $display("gae_return_engine test failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/gae_pkg.sv
src/gae_ram.sv
src/gae_ctrl.sv
src/gae_dp.sv
src/gae_return_engine.sv
tb/gae_return_engine_tb.sv
